FILE: rtl/core/qdrfb_pkg.sv
// Shared types and constants for the quad DAC refresh frame builder.
// No dependencies.
package qdrfb_pkg;

  localparam int FRAME_BYTES = 12;
  localparam int CODE_W      = 12;
  localparam int SETUP_W     = 36;
  localparam int REG_IDX_W   = 3;

  localparam logic [CODE_W-1:0]  CODE_MAX     = 12'hFFF;
  localparam logic [7:0]         DAC_WR_CMD   = 8'h40;
  localparam logic [SETUP_W-1:0] SETUP_RESET  = 36'h00FFF0000;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_PERIOD = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SETUP0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SETUP1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SETUP2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SETUP3 = 3'd4;

  typedef struct packed {
    logic        command;
    logic [1:0]  channel;
    logic [15:0] value;
    logic [31:0] tick_time;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CODE_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/core/quad_dac_refresh_frame_builder_top.sv
// Quad DAC refresh frame builder: value mapping, refresh timing, frame output.
// Depends on qdrfb_pkg and qdrfb_divider.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries tick and set-value
//   transactions. A set value maps the value onto a 12-bit code for one
//   channel; in-range values go through a serial divider and hold in_ready
//   low until the quotient is written, out-of-range values are written directly.
//   A tick whose elapsed time exceeds refresh_period records the time and,
//   if any channel is dirty, sends the 12-byte DAC write frame on the
//   output channel (out_valid/out_ready/out_data), one byte per cycle while
//   out_ready is high; last_byte marks byte 11. in_ready stays low until the
//   frame is fully taken. A stalled receiver holds the current byte.
//   The first byte is offered in the cycle after the tick transaction.
//   Configuration (wr_en/wr_index/wr_data) writes the period or a channel
//   setup; a setup write marks that channel dirty.
//   Reset: period 0, ranges 0..4095, codes 0, all channels dirty.
module quad_dac_refresh_frame_builder_top import qdrfb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [SETUP_W-1:0]   wr_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state;
  logic [31:0]        refresh_period;
  logic [SETUP_W-1:0] setup [4];
  logic [31:0]        last_refresh_time;
  logic [CODE_W-1:0]  channel_code [4];
  logic [3:0]         dirty_flags;
  logic [3:0]         dirty_next;
  logic [1:0]         div_ch;
  logic [1:0]         emit_ch;
  logic [1:0]         emit_part;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               in_fire;
  logic               out_fire;
  logic [SETUP_W-1:0] sel_setup;
  logic signed [16:0] lo;
  logic signed [16:0] hi;
  logic signed [17:0] diff;
  logic [16:0]        span;
  logic               map_zero;
  logic               map_sat;
  logic [31:0]        elapsed;
  logic [CODE_W-1:0]  cur_code;
  logic [SETUP_W-1:0] cur_setup;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  assign sel_setup = setup[in_data.channel];
  assign lo        = 17'(signed'(sel_setup[15:0]));
  assign hi        = 17'(signed'(sel_setup[31:16]));
  assign diff      = signed'({2'b00, in_data.value}) - 18'(lo);
  assign span      = 17'(hi - lo);
  assign map_zero  = (hi <= lo) || (diff <= 18'sd0);
  assign map_sat   = !map_zero && (diff >= signed'({1'b0, span}));
  assign elapsed   = in_data.tick_time - last_refresh_time;

  assign div_req.start    = in_fire && (in_data.command == CMD_SET) && !map_zero && !map_sat;
  assign div_req.dividend = diff[15:0];
  assign div_req.divisor  = span[15:0];

  qdrfb_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    dirty_next = dirty_flags;
    if (in_fire) begin
      if (in_data.command == CMD_SET) begin
        dirty_next[in_data.channel] = 1'b1;
      end else if (elapsed > refresh_period) begin
        dirty_next = 4'h0;
      end
    end
    if (wr_en && (wr_index >= REG_SETUP0) && (wr_index <= REG_SETUP3)) begin
      dirty_next[2'(wr_index - REG_SETUP0)] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      refresh_period    <= '0;
      last_refresh_time <= '0;
      dirty_flags       <= 4'hF;
      emit_ch           <= '0;
      emit_part         <= '0;
      for (int i = 0; i < 4; i++) begin
        setup[i]        <= SETUP_RESET;
        channel_code[i] <= '0;
      end
    end else begin
      dirty_flags <= dirty_next;
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_data.command == CMD_SET) begin
              div_ch <= in_data.channel;
              if (map_zero) begin
                channel_code[in_data.channel] <= '0;
              end else if (map_sat) begin
                channel_code[in_data.channel] <= CODE_MAX;
              end else begin
                state <= ST_DIV;
              end
            end else if (elapsed > refresh_period) begin
              last_refresh_time <= in_data.tick_time;
              if (dirty_flags != 4'h0) begin
                emit_ch     <= '0;
                emit_part   <= '0;
                state       <= ST_EMIT;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            channel_code[div_ch] <= div_rsp.quotient;
            state                <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_fire) begin
            if (emit_part == 2'd2) begin
              emit_part <= '0;
              emit_ch   <= emit_ch + 2'd1;
              if (emit_ch == 2'd3) begin
                state <= ST_IDLE;
              end
            end else begin
              emit_part <= emit_part + 2'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (wr_en) begin
        unique case (wr_index)
          REG_PERIOD: refresh_period <= wr_data[31:0];
          REG_SETUP0, REG_SETUP1, REG_SETUP2, REG_SETUP3: begin
            setup[2'(wr_index - REG_SETUP0)] <= wr_data;
          end
          default: ;
        endcase
      end
    end
  end

  assign cur_code  = channel_code[emit_ch];
  assign cur_setup = setup[emit_ch];

  always_comb begin
    unique case (emit_part)
      2'd0:    out_data.out_byte = DAC_WR_CMD | {5'b0, emit_ch, 1'b0};
      2'd1:    out_data.out_byte = {cur_setup[32], cur_setup[34:33], cur_setup[35],
                                    cur_code[11:8]};
      default: out_data.out_byte = cur_code[7:0];
    endcase
    out_data.last_byte = (emit_ch == 2'd3) && (emit_part == 2'd2);
  end

endmodule

FILE: rtl/core/qdrfb_divider.sv
// Restoring serial divider: (dividend << 12) / divisor, one quotient bit per cycle.
// Expects dividend < divisor. Depends on qdrfb_pkg.
module qdrfb_divider import qdrfb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [15:0]       rem;
  logic [15:0]       divisor;
  logic [CODE_W-1:0] quo;
  logic [3:0]        cnt;
  logic              busy;
  logic              done;
  logic [16:0]       shifted;
  logic              ge;

  assign shifted = {rem, 1'b0};
  assign ge      = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'(CODE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= ge ? 16'(shifted - {1'b0, divisor}) : shifted[15:0];
      quo <= {quo[CODE_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: rtl/core/qdrfb_checker.sv
// Port-level checks for the quad DAC refresh frame builder, bound to the top level.
// Depends on qdrfb_pkg.
module qdrfb_port_checks import qdrfb_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while frame in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled output transaction changed");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last_byte) |=> !out_valid)
    else $error("output continues past last byte");

  a_set_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_data.command == CMD_SET)) |=> !out_valid)
    else $error("set value produced output");

endmodule

bind quad_dac_refresh_frame_builder_top qdrfb_port_checks u_qdrfb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/qdrfb_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the quad DAC refresh frame builder: tracks writes, set-value and tick
// transactions, predicts each frame byte and compares every output transaction.
// Depends on qdrfb_pkg.
module qdrfb_checker import qdrfb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_t                 out_data,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [SETUP_W-1:0]   wr_data,
  output int                   errors,
  output int                   pending
);

  logic [31:0]        period_reg;
  logic [31:0]        last_refresh;
  logic [31:0]        elapsed;
  logic [SETUP_W-1:0] setup_reg [4];
  logic [CODE_W-1:0]  code_reg [4];
  logic [3:0]         dirty;
  logic [1:0]         wr_ch;
  out_t               frame_q [$];
  out_t               want;
  out_t               next_byte;

  function automatic logic [CODE_W-1:0] scale_code(input logic [15:0] value,
                                                   input logic [SETUP_W-1:0] setup);
    longint lo;
    longint hi;
    longint diff;
    longint q;
    lo = longint'($signed(setup[15:0]));
    hi = longint'($signed(setup[31:16]));
    if (hi <= lo) return '0;
    diff = longint'(value) - lo;
    if (diff <= 0) return '0;
    q = diff * (longint'(CODE_MAX) + 1) / (hi - lo);
    if (q > longint'(CODE_MAX)) return CODE_MAX;
    return q[CODE_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      period_reg   = '0;
      last_refresh = '0;
      dirty        = '1;
      frame_q.delete();
      for (int c = 0; c < 4; c++) begin
        setup_reg[c] = SETUP_RESET;
        code_reg[c]  = '0;
      end
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_PERIOD: period_reg = wr_data[31:0];
          REG_SETUP0, REG_SETUP1, REG_SETUP2, REG_SETUP3: begin
            wr_ch            = 2'(wr_index - REG_SETUP0);
            setup_reg[wr_ch] = wr_data;
            dirty[wr_ch]     = 1'b1;
          end
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (frame_q.size() == 0) begin
          $error("unexpected frame byte: out_byte %h last_byte %b",
                 out_data.out_byte, out_data.last_byte);
          errors++;
        end else begin
          want = frame_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte expected %h actual %h", want.out_byte, out_data.out_byte);
            errors++;
          end
          if (out_data.last_byte !== want.last_byte) begin
            $error("last_byte expected %b actual %b", want.last_byte, out_data.last_byte);
            errors++;
          end
        end
      end

      if (in_valid && in_ready) begin
        if (in_data.command == CMD_SET) begin
          code_reg[in_data.channel] = scale_code(in_data.value, setup_reg[in_data.channel]);
          dirty[in_data.channel]    = 1'b1;
        end else begin
          elapsed = in_data.tick_time - last_refresh;
          if (elapsed > period_reg) begin
            last_refresh = in_data.tick_time;
            if (dirty != '0) begin
              for (int c = 0; c < 4; c++) begin
                next_byte.out_byte  = DAC_WR_CMD | 8'(c << 1);
                next_byte.last_byte = 1'b0;
                frame_q.push_back(next_byte);
                next_byte.out_byte  = {setup_reg[c][32], setup_reg[c][34:33],
                                       setup_reg[c][35], code_reg[c][11:8]};
                frame_q.push_back(next_byte);
                next_byte.out_byte  = code_reg[c][7:0];
                next_byte.last_byte = (c == 3);
                frame_q.push_back(next_byte);
              end
              dirty = '0;
            end
          end
        end
      end
    end
    pending = frame_q.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the quad DAC refresh frame builder bench: clock, reset, register writes,
// directed and random stimulus, receiver stalls and verdict. Depends on qdrfb_pkg,
// qdrfb_checker and the RTL top.
module tb_top;
  import qdrfb_pkg::*;

  localparam int                   CYCLE_LIMIT = 500000;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED  = 3'd7;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_t                 out_data;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] wr_index;
  logic [SETUP_W-1:0]   wr_data;
  int                   fail_count;
  int                   pending_bytes;

  int                   send_idle;
  int                   recv_idle;
  int                   cycles;
  int                   item_count;
  int                   roll;
  int                   burst;
  bit                   paused;
  logic [31:0]          now_tick;
  logic [31:0]          period_now;
  logic signed [15:0]   rng_lo [4];
  logic signed [15:0]   rng_hi [4];

  quad_dac_refresh_frame_builder_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  qdrfb_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .errors   (fail_count),
    .pending  (pending_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("quad_dac_refresh_frame_builder_top verification failed");
        $finish;
      end
    end
  end

  task automatic push_item(input in_t item);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_tick(input logic [31:0] t);
    in_t item;
    item.command   = CMD_TICK;
    item.channel   = 2'($urandom);
    item.value     = 16'($urandom);
    item.tick_time = t;
    push_item(item);
  endtask

  task automatic send_set(input logic [1:0] ch, input logic [15:0] v);
    in_t item;
    item.command   = CMD_SET;
    item.channel   = ch;
    item.value     = v;
    item.tick_time = $urandom;
    push_item(item);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [SETUP_W-1:0] data);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = data;
    @(negedge clk);
    wr_en    = 1'b0;
  endtask

  // Hold the sender until all frame bytes are out, then let the divider settle.
  task automatic wait_drain(input int tail);
    in_valid = 1'b0;
    while (pending_bytes != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_value(input logic [1:0] ch);
    int lo;
    int hi;
    if ($urandom_range(1) == 0 || rng_hi[ch] <= rng_lo[ch]) return 16'($urandom);
    lo = (rng_lo[ch] < 0) ? 0 : int'(rng_lo[ch]);
    hi = (rng_hi[ch] < 0) ? 0 : int'(rng_hi[ch]);
    lo = (lo > 20) ? lo - 20 : 0;
    hi = hi + 20;
    return 16'($urandom_range(hi, lo));
  endfunction

  function automatic logic [31:0] next_tick();
    int r;
    r = $urandom_range(99);
    if (r < 70) return now_tick + period_now + 32'd1 + 32'($urandom_range(40));
    if (r < 90) return now_tick + 32'($urandom_range(period_now));
    return $urandom;
  endfunction

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    wr_en      = 1'b0;
    wr_index   = REG_PERIOD;
    wr_data    = '0;
    send_idle  = 0;
    recv_idle  = 0;
    now_tick   = '0;
    period_now = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // reset state: all channels dirty, period 0
    send_tick(32'd0);
    send_tick(32'd1);
    send_tick(32'd2);
    send_set(2'd0, 16'd0);
    send_set(2'd1, 16'd4095);
    send_set(2'd2, 16'hFFFF);
    send_set(2'd3, 16'd2048);
    send_tick(32'hFFFF_FFFF);
    send_set(2'd0, 16'd1);
    send_tick(32'd3);

    wait_drain(24);
    write_reg(REG_PERIOD, {4'h0, 32'hFFFF_FFFF});
    write_reg(REG_SETUP0, {4'h0, 16'sd100, 16'sd100});
    write_reg(REG_SETUP1, {4'hA, 16'hFC18, 16'd1000});
    write_reg(REG_SETUP2, {4'hF, 16'h7FFF, 16'h8000});
    write_reg(REG_SETUP3, {4'h5, 16'd11, 16'd10});
    write_reg(REG_UNUSED, 36'hF_FFFF_FFFF);
    send_tick(32'h1234_5678);
    send_set(2'd0, 16'd500);
    send_set(2'd1, 16'd500);
    send_set(2'd2, 16'd0);
    send_set(2'd3, 16'd5);

    wait_drain(24);
    write_reg(REG_PERIOD, 36'd5);
    send_tick(32'd8);
    send_tick(32'd9);
    send_set(2'd3, 16'd11);
    send_set(2'd2, 16'hFFFF);
    send_set(2'd2, 16'd100);
    send_tick(32'd100);
    wait_drain(24);
    write_reg(REG_SETUP1, {4'h6, 16'd2000, 16'd0});
    send_tick(32'd200);
    now_tick = 32'd200;

    for (int phase = 0; phase < 3; phase++) begin
      wait_drain(24);
      case (phase)
        0: begin
          send_idle  = 22;
          recv_idle  = 64;
          period_now = '0;
        end
        1: begin
          send_idle  = 64;
          recv_idle  = 22;
          period_now = 32'($urandom_range(300, 1));
        end
        default: begin
          send_idle  = 0;
          recv_idle  = 0;
          period_now = 32'($urandom_range(2000, 20));
        end
      endcase
      write_reg(REG_PERIOD, {4'($urandom), period_now});
      for (int ch = 0; ch < 4; ch++) begin
        case ($urandom_range(3))
          0: begin
            rng_lo[ch] = 16'sd0;
            rng_hi[ch] = 16'sd4095;
          end
          1: begin
            rng_lo[ch] = 16'h8000;
            rng_hi[ch] = 16'h7FFF;
          end
          2: begin
            rng_lo[ch] = 16'($urandom_range(30000));
            rng_hi[ch] = rng_lo[ch] + 16'($urandom_range(32767 - int'(rng_lo[ch]), 1));
          end
          default: begin
            rng_lo[ch] = 16'($urandom);
            rng_hi[ch] = 16'($urandom);
          end
        endcase
        write_reg(REG_IDX_W'(REG_SETUP0 + ch), {4'($urandom), rng_hi[ch], rng_lo[ch]});
      end

      item_count = 0;
      paused     = 1'b0;
      while (item_count < 70) begin
        if (item_count >= 35 && !paused) begin
          wait_drain(0);
          paused = 1'b1;
        end
        roll = $urandom_range(99);
        if (roll < 85) begin
          burst = $urandom_range(4);
          repeat (burst) begin
            send_set(2'($urandom), pick_value(2'($urandom)));
          end
          now_tick = next_tick();
          send_tick(now_tick);
          item_count += burst + 1;
        end else if (roll < 93) begin
          send_tick($urandom);
          item_count++;
        end else begin
          send_set(2'($urandom), 16'($urandom));
          item_count++;
        end
      end
    end

    wait_drain(40);
    if (fail_count == 0) begin
      $display("quad_dac_refresh_frame_builder_top verification clean");
    end else begin
      $display("quad_dac_refresh_frame_builder_top verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/qdrfb_pkg.sv
rtl/core/qdrfb_divider.sv
rtl/core/quad_dac_refresh_frame_builder_top.sv
rtl/core/qdrfb_checker.sv
tb/qdrfb_checker.sv
tb/tb_top.sv
